// ===== rtl/ttcq_pkg.sv =====
// Shared types and constants for the time tagged command queue.
`default_nettype none
package ttcq_pkg;

  // Number of cells in the sorted chain
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int HELD_W      = 5;

  // Item kind on the input side
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_t;

  // One stored command
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  sub;
    logic [7:0]  svc;
    logic [31:0] due;
  } entry_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic        insert;     // place new entry, shift later ones right
    logic        shift;      // head leaves, everything moves left
    logic [31:0] time_value; // compare value for this item
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ttcq_cell.sv =====
// One cell of the sorted chain: holds an entry and moves it to a neighbor.
`default_nettype none
module ttcq_cell (
  input  wire logic            clk,
  input  wire ttcq_pkg::ctrl_t ctrl,
  input  wire logic            occ,         // cell index below the fill count
  input  wire logic            left_le,     // left neighbor stays in place
  input  wire ttcq_pkg::entry_t new_entry,
  input  wire ttcq_pkg::entry_t left_entry,
  input  wire ttcq_pkg::entry_t right_entry,
  output logic                 le,          // occupied and due at or before time
  output ttcq_pkg::entry_t     entry
);
  import ttcq_pkg::*;

  entry_t entry_next;

  // Local compare against the broadcast time
  assign le = occ && (entry.due <= ctrl.time_value);

  // Insert: keep when due earlier or equal, else take new or left neighbor; shift: take right neighbor
  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!le) begin
        entry_next = left_le ? new_entry : left_entry;
      end
    end else if (ctrl.shift) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// ===== rtl/time_tagged_command_queue_top.sv =====
// Top level of the time tagged command queue: cell chain, fill count, result register.
// The queue keeps up to QUEUE_DEPTH commands sorted by due second in a chain of cells;
// every cell compares its entry with the item's time in parallel, so an insert or a
// poll is taken every cycle while no result is stalled, and its result is held in the
// output register. Commands with equal due seconds leave in arrival order. A poll
// releases the head entry when it is due at or before the given second, otherwise it
// reports nothing due; an insert into a full queue is dropped with status full. The
// held field gives the entry count after the item (low five bits). Input accepts while
// a result waits as long as the output register is taken in the same cycle.
`default_nettype none
module time_tagged_command_queue_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // time_value[31:0], service[39:32],
                                          // subservice[47:40], tag[63:48]
  input  wire logic [0:0]  s_axis_tuser,  // op[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_service[7:0], out_subservice[15:8],
                                          // out_tag[31:16], held[36:32], zero[39:37]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);
  import ttcq_pkg::*;

  logic             accept;
  logic             is_poll;
  logic             full;
  logic             release_head;
  ctrl_t            ctrl;
  entry_t           new_entry;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [QUEUE_DEPTH-1:0] le;
  entry_t           cell_q [QUEUE_DEPTH];

  status_t          status;
  status_t          status_next;
  logic [7:0]       out_service;
  logic [7:0]       out_subservice;
  logic [15:0]      out_tag;
  logic [HELD_W-1:0] held;

  // Handshake
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_poll       = (s_axis_tuser[0] == OP_POLL);

  assign new_entry.due = s_axis_tdata[31:0];
  assign new_entry.svc = s_axis_tdata[39:32];
  assign new_entry.sub = s_axis_tdata[47:40];
  assign new_entry.tag = s_axis_tdata[63:48];

  // le[0] already includes the non-empty check
  assign full          = (count == CNT_W'(QUEUE_DEPTH));
  assign release_head  = le[0];

  assign ctrl.insert     = accept && !is_poll && !full;
  assign ctrl.shift      = accept && is_poll && release_head;
  assign ctrl.time_value = s_axis_tdata[31:0];

  // Chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_le;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_mid
      assign left_le    = le[i-1];
      assign left_entry = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = new_entry;
    end else begin : g_inner
      assign right_entry = cell_q[i+1];
    end

    ttcq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (CNT_W'(i) < count),
      .left_le     (left_le),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .le          (le[i]),
      .entry       (cell_q[i])
    );
  end

  // Fill count and result code
  always_comb begin
    count_next  = count;
    status_next = ST_NONE_DUE;
    if (!is_poll) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + CNT_W'(1);
      end
    end else if (release_head) begin
      status_next = ST_RELEASED;
      count_next  = count - CNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      held   <= HELD_W'(count_next);
      if (status_next == ST_RELEASED) begin
        out_service    <= cell_q[0].svc;
        out_subservice <= cell_q[0].sub;
        out_tag        <= cell_q[0].tag;
      end else begin
        out_service    <= '0;
        out_subservice <= '0;
        out_tag        <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'b000, held, out_tag, out_subservice, out_service};
  assign m_axis_tuser = status;

endmodule
`default_nettype wire

// ===== rtl/ttcq_checker.sv =====
// Port-level checks for the time tagged command queue and their bind.
`default_nettype none
module ttcq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import ttcq_pkg::*;

  localparam logic [4:0] HELD_FULL = 5'(QUEUE_DEPTH);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Command fields are zero unless a command is released
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_RELEASED |-> m_axis_tdata[31:0] == 32'd0)
    else $error("command fields set without release");

  // A dropped insert means the queue is at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_FULL |-> m_axis_tdata[36:32] == HELD_FULL)
    else $error("full reported below capacity");

  // After a release the queue cannot be at capacity
  a_rel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_RELEASED |-> m_axis_tdata[36:32] != HELD_FULL)
    else $error("release left queue full");

endmodule

bind time_tagged_command_queue_top ttcq_checker u_ttcq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
